// ===== hw/rtl/itoa_pkg.sv =====
// Shared constants and helpers for the integer to radix ASCII converter.
// No dependencies; used by every module under hw/rtl.
`timescale 1ns / 1ps

package itoa_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int RADIX_W        = 6;
  localparam int DIGIT_W        = 6;
  localparam int CHAR_W         = 8;
  localparam int STEP_BITS      = 4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [DIGIT_W-1:0] DIGIT_TOP_DEC = 6'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN     = 6'd10;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DIGIT_TOP_DEC) begin
      c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
    end else begin
      c = CHAR_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

  function automatic logic [RADIX_W-1:0] radix_sat(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] s;
    if (r < RADIX_MIN) begin
      s = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      s = RADIX_MAX;
    end else begin
      s = r;
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/integer_to_radix_ascii.sv =====
// Integer to radix ASCII converter, top level: sequencer, radix register, output.
// Depends on itoa_pkg, itoa_div and itoa_store.
//
// Converts one integer per transaction into its digit characters in the
// configured radix (2 to 36, out-of-range writes saturate), most significant
// first, with tlast on the final character. In radix 10 a negative value is
// preceded by '-'; other radices read the value as unsigned. Each digit comes
// from the shared divider; each character is then read through the registered
// store read port before it is shown, with '-' shown ahead of the digits.
// The input is not ready until the last character has been taken.
`timescale 1ns / 1ps

module integer_to_radix_ascii #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [itoa_pkg::RADIX_W-1:0]  cfg_data,   // radix
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [itoa_pkg::VALUE_W-1:0]  s_tdata,    // value
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [itoa_pkg::CHAR_W-1:0]   m_tdata,    // character
  output logic                          m_tlast
);

  localparam int IDX_W = $clog2(VALUE_BITS);
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SIGN = 5'b00100,
    ST_READ = 5'b01000,
    ST_SHOW = 5'b10000
  } state_t;

  state_t                       state;
  logic [itoa_pkg::RADIX_W-1:0] radix;
  logic                         neg;
  logic [CNT_W-1:0]             count;
  logic [IDX_W-1:0]             idx;

  logic [VALUE_BITS-1:0]        in_val, in_mag, dividend, div_quot;
  logic                         in_neg, in_acc, div_start, div_done;
  logic [itoa_pkg::DIGIT_W-1:0] div_rem, rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itoa_pkg::RADIX_RESET;
    end else if (cfg_valid) begin
      radix <= itoa_pkg::radix_sat(cfg_data);
    end
  end

  assign in_val    = VALUE_BITS'(s_tdata);
  assign in_neg    = (radix == itoa_pkg::RADIX_DEC) && in_val[VALUE_BITS-1];
  assign in_mag    = in_neg ? (~in_val + 1'b1) : in_val;
  assign in_acc    = s_tvalid && s_tready;
  assign div_start = in_acc || ((state == ST_DIV) && div_done && (div_quot != '0));
  assign dividend  = (state == ST_IDLE) ? in_mag : div_quot;

  itoa_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .radix    (radix),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  itoa_store #(
    .DEPTH(VALUE_BITS),
    .IDX_W(IDX_W)
  ) u_store (
    .clk    (clk),
    .wr_en  ((state == ST_DIV) && div_done),
    .wr_addr(count[IDX_W-1:0]),
    .wr_data(div_rem),
    .rd_en  (state == ST_READ),
    .rd_addr(idx),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      neg   <= 1'b0;
      count <= '0;
      idx   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            neg   <= in_neg;
            count <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            count <= count + 1'b1;
            if (div_quot == '0) begin
              idx   <= count[IDX_W-1:0];
              state <= neg ? ST_SIGN : ST_READ;
            end
          end
        end
        ST_SIGN: begin
          if (m_tready) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_SHOW;
        end
        ST_SHOW: begin
          if (m_tready) begin
            if (idx == '0) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx - 1'b1;
              state <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_SIGN) || (state == ST_SHOW);
  assign m_tdata  = (state == ST_SIGN) ? itoa_pkg::CHAR_MINUS : itoa_pkg::digit_char(rd_data);
  assign m_tlast  = (state == ST_SHOW) && (idx == '0);

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready while a character is pending");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not idle after the final character");

  a_divide_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !m_tvalid)
    else $error("output valid straight after an input transaction");

  a_sign_first: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SIGN) |-> (neg && !m_tlast))
    else $error("sign character without a negative value");

endmodule

// ===== hw/rtl/itoa_div.sv =====
// Iterative divider: unsigned value by a small radix, STEP_BITS quotient bits a cycle.
// Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_div #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [VALUE_BITS-1:0]         dividend,
  input  logic [itoa_pkg::RADIX_W-1:0]  radix,
  output logic                          done,
  output logic [VALUE_BITS-1:0]         quotient,
  output logic [itoa_pkg::DIGIT_W-1:0]  remainder
);

  localparam int ITERS  = (VALUE_BITS + itoa_pkg::STEP_BITS - 1) / itoa_pkg::STEP_BITS;
  localparam int PAD    = ITERS * itoa_pkg::STEP_BITS;
  localparam int ITER_W = $clog2(ITERS + 1);
  localparam int RW     = itoa_pkg::DIGIT_W;

  logic [PAD-1:0]    quo, quo_next;
  logic [RW-1:0]     rem, rem_next;
  logic [RW:0]       trial;
  logic [ITER_W-1:0] iter;
  logic              busy;

  always_comb begin
    quo_next = quo;
    rem_next = rem;
    trial    = '0;
    for (int i = 0; i < itoa_pkg::STEP_BITS; i++) begin
      trial    = {rem_next, quo_next[PAD-1]};
      quo_next = {quo_next[PAD-2:0], 1'b0};
      if (trial >= {1'b0, radix}) begin
        trial       = trial - {1'b0, radix};
        quo_next[0] = 1'b1;
      end
      rem_next = trial[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= ITER_W'(ITERS);
      end else if (busy) begin
        iter <= iter - 1'b1;
        if (iter == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= PAD'(dividend);
      rem <= '0;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient  = quo[VALUE_BITS-1:0];
  assign remainder = rem;

endmodule

// ===== hw/rtl/itoa_store.sv =====
// Digit store: one write port, one registered read port.
// Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_store #(
  parameter int DEPTH = itoa_pkg::VALUE_BITS_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [IDX_W-1:0]             wr_addr,
  input  logic [itoa_pkg::DIGIT_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [IDX_W-1:0]             rd_addr,
  output logic [itoa_pkg::DIGIT_W-1:0] rd_data
);

  logic [itoa_pkg::DIGIT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== tb/sv/integer_to_radix_ascii_tb.sv =====
// Testbench for integer_to_radix_ascii: checks each digit string against typed text or a local predictor.
// Uses a typed table of directed values, then random values under several idle and stall patterns.
// Depends on itoa_pkg and the integer_to_radix_ascii RTL.
`timescale 1ns / 1ps

module integer_to_radix_ascii_tb;

  localparam int CHAR_W      = itoa_pkg::CHAR_W;
  localparam int RADIX_W     = itoa_pkg::RADIX_W;
  localparam int VALUE_W     = itoa_pkg::VALUE_W;
  localparam int DIGIT_W     = itoa_pkg::DIGIT_W;

  localparam int LIMIT       = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;
  localparam int SHOW_MAX    = 10;
  localparam int BLOCK_ITEMS = 11;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } glyph_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_valid = 1'b0;
  logic [RADIX_W-1:0]  cfg_data  = '0;
  logic                s_tvalid  = 1'b0;
  logic [VALUE_W-1:0]  s_tdata   = '0;
  logic                m_tready  = 1'b0;
  logic                cfg_ready;
  logic                s_tready;
  logic                m_tvalid;
  logic [CHAR_W-1:0]   m_tdata;
  logic                m_tlast;

  glyph_t              pending_glyphs[$];
  glyph_t              want;
  logic [RADIX_W-1:0]  radix_reg = itoa_pkg::RADIX_RESET;
  logic [RADIX_W-1:0]  row_radix[$];
  logic [VALUE_W-1:0]  row_value[$];
  string               row_text[$];

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  bit hold_trigger    = 1'b0;
  logic hold_active   = 1'b0;
  int mismatches      = 0;
  int chars_seen      = 0;
  int strings_done    = 0;
  int values_sent     = 0;
  int radix_writes    = 0;
  int cycles          = 0;

  integer_to_radix_ascii u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned base_of(input logic [RADIX_W-1:0] r);
    if (r < itoa_pkg::RADIX_MIN) begin
      return itoa_pkg::RADIX_MIN;
    end
    if (r > itoa_pkg::RADIX_MAX) begin
      return itoa_pkg::RADIX_MAX;
    end
    return r;
  endfunction

  function automatic void spell_value(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] digits[VALUE_W];
    int unsigned        base;
    int                 count;
    glyph_t             g;
    base = base_of(radix_reg);
    quotient = value;
    if (base == itoa_pkg::RADIX_DEC && value[VALUE_W-1]) begin
      quotient = -value;
      g.ch = itoa_pkg::CHAR_MINUS;
      g.last = 1'b0;
      pending_glyphs.push_back(g);
    end
    count = 0;
    do begin
      digits[count] = DIGIT_W'(quotient % base);
      count++;
      quotient = quotient / base;
    end while (quotient != 0);
    for (int k = count - 1; k >= 0; k--) begin
      if (digits[k] > itoa_pkg::DIGIT_TOP_DEC) begin
        g.ch = itoa_pkg::CHAR_A + CHAR_W'(digits[k] - itoa_pkg::DIGIT_TEN);
      end else begin
        g.ch = itoa_pkg::CHAR_ZERO + CHAR_W'(digits[k]);
      end
      g.last = (k == 0);
      pending_glyphs.push_back(g);
    end
  endfunction

  function automatic void queue_typed_text(input string text);
    glyph_t g;
    for (int i = 0; i < text.len(); i++) begin
      g.ch = text[i];
      g.last = (i == text.len() - 1);
      pending_glyphs.push_back(g);
    end
  endfunction

  function automatic void add_row(input logic [RADIX_W-1:0] r, input logic [VALUE_W-1:0] v,
                                  input string text);
    row_radix.push_back(r);
    row_value.push_back(v);
    row_text.push_back(text);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] p;
    int unsigned        sel;
    int unsigned        base;
    int unsigned        k;
    sel = $urandom_range(99, 0);
    base = base_of(radix_reg);
    if (sel < 40) begin
      return $urandom();
    end
    if (sel < 60) begin
      return $urandom_range(40, 0);
    end
    if (sel < 75) begin
      p = $urandom_range(1000, 1);
      return -p;
    end
    if (sel < 85) begin
      case ($urandom_range(5, 0))
        0: return 32'h0000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h8000_0000;
        3: return 32'hffff_ffff;
        4: return 32'h8000_0001;
        default: return 32'h0000_0001;
      endcase
    end
    // land near a power of the radix to hit digit-count boundaries
    p = 1;
    k = $urandom_range(31, 1);
    repeat (k) begin
      if (p <= 32'hffff_ffff / base) begin
        p = p * base;
      end
    end
    return p - 1 + $urandom_range(2, 0);
  endfunction

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    s_tvalid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radix_reg = r;
    radix_writes++;
  endtask

  task automatic send_value(input logic [VALUE_W-1:0] value, input string text);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    if (text.len() == 0) begin
      spell_value(value);
    end else begin
      queue_typed_text(text);
    end
    values_sent++;
  endtask

  always @(posedge clk) begin
    if (rst || hold_active) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // long receiver hold-off, counted here so the converter backs up into its input
  initial begin
    wait (hold_trigger);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      chars_seen++;
      if (m_tlast) begin
        strings_done++;
      end
      if (pending_glyphs.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX) begin
          $display("unexpected character: got %h last %b", m_tdata, m_tlast);
        end
      end else begin
        want = pending_glyphs.pop_front();
        if (want.ch !== m_tdata || want.last !== m_tlast) begin
          mismatches++;
          if (mismatches <= SHOW_MAX) begin
            $display("character %0d mismatch: expected %h last %b, got %h last %b",
                     chars_seen, want.ch, want.last, m_tdata, m_tlast);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding",
               cycles, pending_glyphs.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [RADIX_W-1:0] block_radix;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(6'd10, 32'd0,          "0");
    add_row(6'd10, 32'd9,          "9");
    add_row(6'd10, 32'd10,         "10");
    add_row(6'd10, 32'h7fff_ffff,  "2147483647");
    add_row(6'd10, 32'h8000_0000,  "-2147483648");
    add_row(6'd10, 32'hffff_ffff,  "-1");
    add_row(6'd10, 32'hffff_ff85,  "-123");
    add_row(6'd10, 32'h5a5a_5a5a,  "");
    add_row(6'd16, 32'hffff_ffff,  "ffffffff");
    add_row(6'd16, 32'hdead_beef,  "deadbeef");
    add_row(6'd16, 32'h8000_0000,  "80000000");
    add_row(6'd2,  32'hffff_ffff,  "11111111111111111111111111111111");
    add_row(6'd2,  32'h8000_0000,  "10000000000000000000000000000000");
    add_row(6'd2,  32'd0,          "0");
    add_row(6'd36, 32'd35,         "z");
    add_row(6'd36, 32'd36,         "10");
    add_row(6'd36, 32'hffff_ffff,  "1z141z3");
    add_row(6'd8,  32'hffff_ffff,  "37777777777");
    add_row(6'd3,  32'h1234_5678,  "");
    add_row(6'd0,  32'd5,          "101");
    add_row(6'd1,  32'd6,          "110");
    add_row(6'd63, 32'd35,         "z");
    add_row(6'd63, 32'ha5a5_a5a5,  "");
    add_row(6'd37, 32'd71,         "1z");

    foreach (row_value[i]) begin
      if (row_radix[i] != radix_reg) begin
        write_radix(row_radix[i]);
      end
      send_value(row_value[i], row_text[i]);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 60; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 60; end
        default: begin sender_idle_pct = 9; stall_pct = 9; end
      endcase
      for (int blk = 0; blk < 3; blk++) begin
        case (blk)
          0: block_radix = (phase == 0) ? 6'd10 : (phase == 1) ? 6'd2 :
                           (phase == 2) ? 6'd36 : 6'd0;
          1: block_radix = (phase == 0) ? 6'd16 : (phase == 1) ? 6'd63 :
                           (phase == 2) ? 6'd10 : 6'd8;
          default: block_radix = RADIX_W'($urandom_range(63, 0));
        endcase
        write_radix(block_radix);
        if (phase == 0 && blk == 1) begin
          hold_trigger = 1'b1;
        end
        repeat (BLOCK_ITEMS) send_value(pick_value(), "");
      end
    end

    s_tvalid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Converted %0d values into %0d characters (%0d strings) over %0d radix writes",
             values_sent, chars_seen, strings_done, radix_writes);
    $display("Flow patterns: free-running, sender gaps, receiver stalls, both, %0d-cycle hold-off",
             HOLD_CYCLES);
    if (mismatches == 0 && pending_glyphs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d characters outstanding", mismatches, pending_glyphs.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== integer_to_radix_ascii.f =====
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_div.sv
hw/rtl/itoa_store.sv
hw/rtl/integer_to_radix_ascii.sv
tb/sv/integer_to_radix_ascii_tb.sv
